// ===== design/e2q_pkg.sv =====
// Package for the Euler-angle to quaternion core: payload types, CORDIC
// constants and the arctangent table. No dependencies.
`default_nettype none
package e2q_pkg;
   localparam int ANGLE_BITS    = 16;
   localparam int FRAC_BITS     = 14;
   localparam int CORDIC_STAGES = 16;
   localparam int CW            = 33;  // CORDIC x/y/z width
   localparam int QW            = 16;
   localparam int AXES          = 3;
   localparam logic signed [CW-1:0] INV_GAIN_Q30 = 33'sd652032874;

   typedef logic [$clog2(CORDIC_STAGES)-1:0] stage_idx_type;

   typedef struct packed {
      logic signed [ANGLE_BITS-1:0] roll_angle;
      logic signed [ANGLE_BITS-1:0] pitch_angle;
      logic signed [ANGLE_BITS-1:0] yaw_angle;
   } req_type;

   typedef struct packed {
      logic signed [QW-1:0] quat_x;
      logic signed [QW-1:0] quat_y;
      logic signed [QW-1:0] quat_z;
      logic signed [QW-1:0] quat_w;
   } rsp_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } rot_type;

   function automatic logic signed [CW-1:0] atan_lookup(input int i);
      logic [31:0] t [32];
      t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
            32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
            32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
            32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
      return $signed({1'b0, t[i & 31]});
   endfunction

   function automatic logic signed [CW-1:0] half_angle(input logic [ANGLE_BITS-1:0] a);
      logic signed [CW-1:0] s;
      s = CW'($signed(a));
      if (ANGLE_BITS <= 31) return s <<< (31 - ANGLE_BITS);
      return s >>> 1;
   endfunction
endpackage
`default_nettype wire

// ===== design/e2q_cell.sv =====
// One CORDIC rotation cell: a single micro-rotation for the three axes.
// Depends on e2q_pkg.
`default_nettype none
module e2q_cell import e2q_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire stage_idx_type stage,
   input  wire logic          valid_in,
   input  wire rot_type       rot_in [AXES],
   output logic               valid_out,
   output rot_type            rot_out [AXES]
);
   logic    valid_ff;
   rot_type rot_ff [AXES];
   rot_type rot_in_v [AXES];
   logic signed [CW-1:0] ang;

   always_comb begin
      ang = atan_lookup(int'(stage));
      for (int a = 0; a < AXES; a++) begin
         if (!rot_in[a].z[CW-1]) begin
            rot_in_v[a].x = rot_in[a].x - (rot_in[a].y >>> stage);
            rot_in_v[a].y = rot_in[a].y + (rot_in[a].x >>> stage);
            rot_in_v[a].z = rot_in[a].z - ang;
         end else begin
            rot_in_v[a].x = rot_in[a].x + (rot_in[a].y >>> stage);
            rot_in_v[a].y = rot_in[a].y - (rot_in[a].x >>> stage);
            rot_in_v[a].z = rot_in[a].z + ang;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      rot_ff <= rot_in_v;
   end

   assign valid_out = valid_ff;
   assign rot_out   = rot_ff;
endmodule
`default_nettype wire

// ===== design/e2q_combine.sv =====
// Product stages: pair products, triple products, rounding and clamp.
// Depends on e2q_pkg.
`default_nettype none
module e2q_combine import e2q_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    valid_in,
   input  wire rot_type rot_in [AXES],
   output logic         valid_out,
   output rsp_type      rsp_out
);
   localparam int SH = 60 - FRAC_BITS;
   logic [2:0] valid_ff;
   logic signed [CW-1:0] c3_ff, s3_ff;
   logic signed [65:0] cc_p_ff, sc_p_ff, cs_p_ff, ss_p_ff;
   logic signed [CW-1:0] c3b_ff, s3b_ff;
   logic signed [CW-1:0] cc_ff, sc_ff, cs_ff, ss_ff;
   logic signed [65:0] t_ff [8];
   rsp_type rsp_ff;
   logic signed [66:0] sum_in [4];

   function automatic logic signed [CW-1:0] rnd30(input logic signed [65:0] v);
      logic signed [65:0] r;
      r = (v + 66'sd536870912) >>> 30;
      return r[CW-1:0];
   endfunction

   function automatic logic signed [QW-1:0] finish(input logic signed [66:0] v);
      logic signed [66:0] r;
      logic signed [66:0] one;
      r = (v + (67'sd1 <<< (SH - 1))) >>> SH;
      one = 67'sd1 <<< FRAC_BITS;
      if (r > one) r = one;
      if (r < -one) r = -one;
      if (r > 67'sd32767) r = 67'sd32767;
      if (r < -67'sd32768) r = -67'sd32768;
      return r[QW-1:0];
   endfunction

   always_comb begin
      sum_in[0] = 67'(t_ff[0]) + 67'(t_ff[1]);
      sum_in[1] = 67'(t_ff[2]) - 67'(t_ff[3]);
      sum_in[2] = 67'(t_ff[4]) + 67'(t_ff[5]);
      sum_in[3] = 67'(t_ff[6]) - 67'(t_ff[7]);
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else       valid_ff <= {valid_ff[1:0], valid_in};
      cc_p_ff <= 66'(rot_in[0].x) * 66'(rot_in[1].x);
      sc_p_ff <= 66'(rot_in[0].y) * 66'(rot_in[1].x);
      cs_p_ff <= 66'(rot_in[0].x) * 66'(rot_in[1].y);
      ss_p_ff <= 66'(rot_in[0].y) * 66'(rot_in[1].y);
      c3_ff   <= rot_in[2].x;
      s3_ff   <= rot_in[2].y;
      cc_ff   <= rnd30(cc_p_ff);
      sc_ff   <= rnd30(sc_p_ff);
      cs_ff   <= rnd30(cs_p_ff);
      ss_ff   <= rnd30(ss_p_ff);
      c3b_ff  <= c3_ff;
      s3b_ff  <= s3_ff;
      t_ff[0] <= 66'(sc_ff) * 66'(c3b_ff);
      t_ff[1] <= 66'(cs_ff) * 66'(s3b_ff);
      t_ff[2] <= 66'(cs_ff) * 66'(c3b_ff);
      t_ff[3] <= 66'(sc_ff) * 66'(s3b_ff);
      t_ff[4] <= 66'(cc_ff) * 66'(s3b_ff);
      t_ff[5] <= 66'(ss_ff) * 66'(c3b_ff);
      t_ff[6] <= 66'(cc_ff) * 66'(c3b_ff);
      t_ff[7] <= 66'(ss_ff) * 66'(s3b_ff);
   end

   logic valid_o_ff;
   always_ff @(posedge clock) begin
      if (reset) valid_o_ff <= 1'b0;
      else       valid_o_ff <= valid_ff[2];
      rsp_ff.quat_x <= finish(sum_in[0]);
      rsp_ff.quat_y <= finish(sum_in[1]);
      rsp_ff.quat_z <= finish(sum_in[2]);
      rsp_ff.quat_w <= finish(sum_in[3]);
   end

   assign valid_out = valid_o_ff;
   assign rsp_out   = rsp_ff;
endmodule
`default_nettype wire

// ===== design/euler_to_quaternion_core.sv =====
// Top level: chain of CORDIC cells feeding the product stages.
// Depends on e2q_pkg, e2q_cell and e2q_combine.
//
// Takes one angle triple every cycle (busy is always low) and gives its
// quaternion through the registered cell chain and then the product
// stages. The receiver cannot stall: rsp_valid pulses for one cycle per
// result.
`default_nettype none
module euler_to_quaternion_core import e2q_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);
   logic    v_chain [CORDIC_STAGES+1];
   rot_type r_chain [CORDIC_STAGES+1][AXES];

   assign busy = 1'b0;
   assign v_chain[0] = start;
   always_comb begin
      r_chain[0][0] = '{x: INV_GAIN_Q30, y: '0, z: half_angle(req_data.roll_angle)};
      r_chain[0][1] = '{x: INV_GAIN_Q30, y: '0, z: half_angle(req_data.pitch_angle)};
      r_chain[0][2] = '{x: INV_GAIN_Q30, y: '0, z: half_angle(req_data.yaw_angle)};
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      e2q_cell u_cell (
         .clock, .reset,
         .stage(stage_idx_type'(i)),
         .valid_in(v_chain[i]), .rot_in(r_chain[i]),
         .valid_out(v_chain[i+1]), .rot_out(r_chain[i+1])
      );
   end

   e2q_combine u_comb (
      .clock, .reset,
      .valid_in(v_chain[CORDIC_STAGES]), .rot_in(r_chain[CORDIC_STAGES]),
      .valid_out(rsp_valid), .rsp_out(rsp_data)
   );

   a_busy: assert property (@(posedge clock) busy == 1'b0) else $error("busy");
   a_lat: assert property (@(posedge clock) disable iff (reset)
      v_chain[CORDIC_STAGES] |-> ##4 rsp_valid) else $error("latency");
   a_x: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.quat_x <= 16'sd16384 && rsp_data.quat_x >= -16'sd16384))
      else $error("range");
endmodule
`default_nettype wire

// ===== sim/euler_to_quaternion_core_tb.sv =====
// Testbench for euler_to_quaternion_core: drives angle triples, predicts each
// quaternion with a CORDIC model of its own and checks every result beat.
// Depends on e2q_pkg and the core.
`default_nettype none
module euler_to_quaternion_core_tb;
   import e2q_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = CORDIC_STAGES + 4;
   localparam longint CYCLE_LIMIT = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   rsp_type quat_queue[$];
   int      mismatches = 0;
   int      beats_sent = 0;
   int      beats_checked = 0;
   longint  cycles = 0;

   euler_to_quaternion_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint floor_shift(longint v, int sh);
      return v >>> sh;
   endfunction

   function automatic longint round_down(longint v, int sh);
      return floor_shift(v + (longint'(1) << (sh - 1)), sh);
   endfunction

   function automatic longint atan_step(int i);
      longint t [16];
      t = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
            64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
            64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
            64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
      return t[i];
   endfunction

   task automatic half_sincos(input logic [ANGLE_BITS-1:0] a,
                              output longint c, output longint s);
      longint x, y, z, dx, dy;
      x = 652032874;
      y = 0;
      z = longint'($signed(a)) <<< (31 - ANGLE_BITS);
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_step(i);
         end else begin
            x += dx; y -= dy; z += atan_step(i);
         end
      end
      c = x;
      s = y;
   endtask

   function automatic logic signed [QW-1:0] to_component(longint q60);
      longint v, one;
      v = round_down(q60, 60 - FRAC_BITS);
      one = longint'(1) << FRAC_BITS;
      if (v > one) v = one;
      if (v < -one) v = -one;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[QW-1:0];
   endfunction

   task automatic predict_quat(input req_type r, output rsp_type q);
      longint c1, s1, c2, s2, c3, s3, cc, sc, cs, ss;
      half_sincos(r.roll_angle, c1, s1);
      half_sincos(r.pitch_angle, c2, s2);
      half_sincos(r.yaw_angle, c3, s3);
      cc = round_down(c1 * c2, 30);
      sc = round_down(s1 * c2, 30);
      cs = round_down(c1 * s2, 30);
      ss = round_down(s1 * s2, 30);
      q.quat_x = to_component(sc * c3 + cs * s3);
      q.quat_y = to_component(cs * c3 - sc * s3);
      q.quat_z = to_component(cc * s3 + ss * c3);
      q.quat_w = to_component(cc * c3 - ss * s3);
   endtask

   // one beat; start stays high across back-to-back beats
   task automatic send_angles(input req_type r, input bit hold);
      rsp_type q;
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      predict_quat(r, q);
      quat_queue.push_back(q);
      beats_sent++;
      @(negedge clock);
      if (!hold) begin
         start <= 1'b0;
         @(negedge clock);
      end
   endtask

   task automatic send_burst(input req_type r[$]);
      foreach (r[i]) send_angles(r[i], i != r.size() - 1);
   endtask

   function automatic req_type rand_angles();
      req_type r;
      r = req_type'(48'({$urandom, $urandom}));
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type q;
      cycles++;
      if (!reset && rsp_valid) begin
         if (quat_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", rsp_data);
         end else begin
            q = quat_queue.pop_front();
            beats_checked++;
            if (rsp_data !== q) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("beat %0d: expected x %0d y %0d z %0d w %0d, got %0d %0d %0d %0d",
                           beats_checked, q.quat_x, q.quat_y, q.quat_z, q.quat_w,
                           rsp_data.quat_x, rsp_data.quat_y, rsp_data.quat_z,
                           rsp_data.quat_w);
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("euler_to_quaternion_core_tb: done, errors");
         $finish;
      end
   end

   task automatic test_extremes();
      logic signed [15:0] v [8];
      req_type b[$];
      v = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001,
            16'sh4000, 16'shC000, 16'sh2000};
      for (int i = 0; i < 8; i++) begin
         b.push_back('{v[i], v[(i + 3) % 8], v[(i + 5) % 8]});
      end
      b.push_back('{16'sh8000, 16'sh8000, 16'sh8000});
      b.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
      send_burst(b);
   endtask

   // single axis rotations, and an opposite roll angle pair giving conjugate quaternions
   task automatic test_single_axis();
      req_type b[$];
      b.push_back('{16'sh4000, 16'sh0, 16'sh0});
      b.push_back('{16'sh0, 16'sh4000, 16'sh0});
      b.push_back('{16'sh0, 16'sh0, 16'sh4000});
      b.push_back('{16'sh7000, 16'sh0, 16'sh0});
      b.push_back('{16'sh9000, 16'sh0, 16'sh0});
      b.push_back('{16'sh0, 16'sh0, 16'shA000});
      foreach (b[i]) send_angles(b[i], 1'b0);
   endtask

   task automatic test_random(input int n);
      int left;
      left = n;
      while (left > 0) begin
         int len;
         req_type b[$];
         len = $urandom_range(1, 24);
         if (len > left) len = left;
         for (int i = 0; i < len; i++) b.push_back(rand_angles());
         send_burst(b);
         left -= len;
         if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extremes();
      test_single_axis();
      test_random(850);
      while (quat_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      $display("%0d angle triples sent, %0d quaternions checked, %0d mismatches",
               beats_sent, beats_checked, mismatches);
      if (mismatches == 0)
         $display("euler_to_quaternion_core_tb: done, clean");
      else
         $display("euler_to_quaternion_core_tb: done, errors");
      $finish;
   end
endmodule
`default_nettype wire

// ===== euler_to_quaternion_core.f =====
design/e2q_pkg.sv
design/e2q_cell.sv
design/e2q_combine.sv
design/euler_to_quaternion_core.sv
sim/euler_to_quaternion_core_tb.sv
